FILE: rtl/timhp_pkg.sv
// Shared types, constants and helpers for the TIM image header parser.
// Depends on nothing; every other file of the block imports it.
package timhp_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 30;
  localparam int unsigned CoordW = 16;

  localparam logic [WordW-1:0]  TimMagic      = 32'h0000_0010;
  localparam int unsigned       ClutBit       = 3;
  localparam logic [CountW-1:0] BlockHdrWords = 30'd3;
  localparam logic [WordW-1:0]  HeaderWords   = 32'd2;

  typedef enum logic [3:0] {
    PH_MAGIC = 4'd0,
    PH_FLAGS = 4'd1,
    PH_CLEN  = 4'd2,
    PH_CXY   = 4'd3,
    PH_CWH   = 4'd4,
    PH_CSKIP = 4'd5,
    PH_PLEN  = 4'd6,
    PH_PXY   = 4'd7,
    PH_PWH   = 4'd8,
    PH_PSKIP = 4'd9
  } phase_t;

  typedef struct packed {
    logic                     status;
    logic [WordW-1:0]         flags;
    logic                     has_clut;
    logic signed [CoordW-1:0] clut_x;
    logic signed [CoordW-1:0] clut_y;
    logic signed [CoordW-1:0] clut_w;
    logic signed [CoordW-1:0] clut_h;
    logic signed [CoordW-1:0] pix_x;
    logic signed [CoordW-1:0] pix_y;
    logic signed [CoordW-1:0] pix_w;
    logic signed [CoordW-1:0] pix_h;
    logic [WordW-1:0]         total_words;
  } result_t;

  // Words of block data after the length word and the two rectangle words.
  function automatic logic [CountW-1:0] data_words(input logic [CountW-1:0] block_words);
    return (block_words > BlockHdrWords) ? (block_words - BlockHdrWords) : '0;
  endfunction

endpackage

FILE: rtl/timhp_in_reg.sv
// Input register of the TIM header parser: holds one stream word and its restart flag.
// Depends on timhp_pkg for the word width.
module timhp_in_reg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [timhp_pkg::WordW-1:0] word,
  input  logic                       restart,
  output logic                       item_valid,
  output logic [timhp_pkg::WordW-1:0] item_word,
  output logic                       item_restart,
  input  logic                       take
);
  import timhp_pkg::*;

  assign in_stall = item_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_word    <= word;
      item_restart <= restart;
    end
  end

endmodule

FILE: rtl/timhp_parser.sv
// Header parse state machine: walks the phases of a TIM image one word at a time.
// Depends on timhp_pkg for the phase type, result record and block helpers.
module timhp_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  input  logic [timhp_pkg::WordW-1:0] item_word,
  input  logic                        item_restart,
  output logic                        take,
  input  logic                        out_free,
  output logic                        res_valid,
  output timhp_pkg::result_t          res
);
  import timhp_pkg::*;

  phase_t              phase, phase_next, ph;
  logic [CountW-1:0]   skip_count, skip_count_next;
  logic [WordW-1:0]    held_flags, held_flags_next;
  logic [CountW-1:0]   clut_words, clut_words_next;
  logic [2*WordW-1:0]  held_clut_rect, held_clut_rect_next;
  logic [CountW-1:0]   pixel_words, pixel_words_next;
  logic [WordW-1:0]    held_pix_xy, held_pix_xy_next;
  logic [CountW-1:0]   skip_dec;
  logic                res_hit;

  assign ph       = item_restart ? PH_MAGIC : phase;
  assign skip_dec = skip_count - 1'b1;

  always_comb begin
    phase_next          = ph;
    skip_count_next     = skip_count;
    held_flags_next     = held_flags;
    clut_words_next     = clut_words;
    held_clut_rect_next = held_clut_rect;
    pixel_words_next    = pixel_words;
    held_pix_xy_next    = held_pix_xy;
    unique case (ph)
      PH_FLAGS: begin
        held_flags_next     = item_word;
        clut_words_next     = '0;
        held_clut_rect_next = '0;
        phase_next          = item_word[ClutBit] ? PH_CLEN : PH_PLEN;
      end
      PH_CLEN: begin
        clut_words_next = item_word[WordW-1:2];
        phase_next      = PH_CXY;
      end
      PH_CXY: begin
        held_clut_rect_next = {{WordW{1'b0}}, item_word};
        phase_next          = PH_CWH;
      end
      PH_CWH: begin
        held_clut_rect_next = {item_word, held_clut_rect[WordW-1:0]};
        skip_count_next     = data_words(clut_words);
        phase_next          = (data_words(clut_words) != '0) ? PH_CSKIP : PH_PLEN;
      end
      PH_CSKIP: begin
        skip_count_next = skip_dec;
        if (skip_dec == '0) begin
          phase_next = PH_PLEN;
        end
      end
      PH_PLEN: begin
        pixel_words_next = item_word[WordW-1:2];
        phase_next       = PH_PXY;
      end
      PH_PXY: begin
        held_pix_xy_next = item_word;
        phase_next       = PH_PWH;
      end
      PH_PWH: begin
        skip_count_next = data_words(pixel_words);
        phase_next      = (data_words(pixel_words) != '0) ? PH_PSKIP : PH_MAGIC;
      end
      PH_PSKIP: begin
        skip_count_next = skip_dec;
        if (skip_dec == '0) begin
          phase_next = PH_MAGIC;
        end
      end
      default: begin
        phase_next = (item_word == TimMagic) ? PH_FLAGS : PH_MAGIC;
      end
    endcase
  end

  always_comb begin
    res     = '0;
    res_hit = 1'b0;
    unique case (ph) inside
      PH_FLAGS, PH_CLEN, PH_CXY, PH_CWH, PH_CSKIP, PH_PLEN, PH_PXY, PH_PSKIP: begin
        res_hit = 1'b0;
      end
      PH_PWH: begin
        res_hit          = 1'b1;
        res.flags        = held_flags;
        res.has_clut     = held_flags[ClutBit];
        res.clut_x       = $signed(held_clut_rect[15:0]);
        res.clut_y       = $signed(held_clut_rect[31:16]);
        res.clut_w       = $signed(held_clut_rect[47:32]);
        res.clut_h       = $signed(held_clut_rect[63:48]);
        res.pix_x        = $signed(held_pix_xy[15:0]);
        res.pix_y        = $signed(held_pix_xy[31:16]);
        res.pix_w        = $signed(item_word[15:0]);
        res.pix_h        = $signed(item_word[31:16]);
        res.total_words  = {2'b00, clut_words} + {2'b00, pixel_words} + HeaderWords;
      end
      default: begin
        res_hit    = (item_word != TimMagic);
        res.status = 1'b1;
      end
    endcase
  end

  assign take      = item_valid && (!res_hit || out_free);
  assign res_valid = take && res_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_MAGIC;
      skip_count     <= '0;
      held_flags     <= '0;
      clut_words     <= '0;
      held_clut_rect <= '0;
      pixel_words    <= '0;
      held_pix_xy    <= '0;
    end else if (take) begin
      phase          <= phase_next;
      skip_count     <= skip_count_next;
      held_flags     <= held_flags_next;
      clut_words     <= clut_words_next;
      held_clut_rect <= held_clut_rect_next;
      pixel_words    <= pixel_words_next;
      held_pix_xy    <= held_pix_xy_next;
    end
  end

endmodule

FILE: rtl/timhp_out_reg.sv
// Result register of the TIM header parser: holds one header or error record.
// Depends on timhp_pkg for the result record type.
module timhp_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               res_valid,
  input  timhp_pkg::result_t res,
  output logic               out_free,
  output logic               out_valid,
  input  logic               out_stall,
  output timhp_pkg::result_t out_res
);
  import timhp_pkg::*;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      out_res <= res;
    end
  end

endmodule

FILE: rtl/tim_image_header_parser_unit.sv
// Top level of the TIM image header parser.
// A word that completes a header or fails the magic check has its record on the outputs
// once it has passed the input register and then the result register; out_stall can hold it.
// Throughput: one stream word per cycle unless a record waits on out_stall.
// Reset: rst is synchronous; the parser waits for a magic word and both registers empty.
// Depends on timhp_pkg, timhp_in_reg, timhp_parser and timhp_out_reg.
module tim_image_header_parser_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [timhp_pkg::WordW-1:0]         word,
  input  logic                                restart,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                status,
  output logic [timhp_pkg::WordW-1:0]         flags,
  output logic                                has_clut,
  output logic signed [timhp_pkg::CoordW-1:0] clut_x,
  output logic signed [timhp_pkg::CoordW-1:0] clut_y,
  output logic signed [timhp_pkg::CoordW-1:0] clut_w,
  output logic signed [timhp_pkg::CoordW-1:0] clut_h,
  output logic signed [timhp_pkg::CoordW-1:0] pix_x,
  output logic signed [timhp_pkg::CoordW-1:0] pix_y,
  output logic signed [timhp_pkg::CoordW-1:0] pix_w,
  output logic signed [timhp_pkg::CoordW-1:0] pix_h,
  output logic [timhp_pkg::WordW-1:0]         total_words
);
  import timhp_pkg::*;

  logic             item_valid;
  logic [WordW-1:0] item_word;
  logic             item_restart;
  logic             take;
  logic             out_free;
  logic             res_valid;
  result_t          res;
  result_t          out_res;

  timhp_in_reg u_in_reg (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .word         (word),
    .restart      (restart),
    .item_valid   (item_valid),
    .item_word    (item_word),
    .item_restart (item_restart),
    .take         (take)
  );

  timhp_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_word    (item_word),
    .item_restart (item_restart),
    .take         (take),
    .out_free     (out_free),
    .res_valid    (res_valid),
    .res          (res)
  );

  timhp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign status      = out_res.status;
  assign flags       = out_res.flags;
  assign has_clut    = out_res.has_clut;
  assign clut_x      = out_res.clut_x;
  assign clut_y      = out_res.clut_y;
  assign clut_w      = out_res.clut_w;
  assign clut_h      = out_res.clut_h;
  assign pix_x       = out_res.pix_x;
  assign pix_y       = out_res.pix_y;
  assign pix_w       = out_res.pix_w;
  assign pix_h       = out_res.pix_h;
  assign total_words = out_res.total_words;

endmodule
